// ===== sv/d3r_pkg.sv =====
package d3r_pkg;

	localparam int DispW   = 16;
	localparam int PixW    = 12;
	localparam int RegW    = 32;
	localparam int ProdW   = DispW + RegW;       // disparity * q32
	localparam int DenW    = ProdW + 1;          // exact denominator, 32 fraction bits
	localparam int NumW    = RegW + 2;           // exact numerator, 16 fraction bits
	localparam int QuotW   = 32;                 // quotient bits produced by the divider
	localparam int RemW    = DenW;               // remainder stays below the divisor
	localparam int CfgAddrW = 3;
	localparam int MaxColsDefault = 4096;
	localparam int MaxRowsDefault = 4096;

	typedef enum logic [CfgAddrW-1:0] {
		CFG_Q03 = 3'd0,
		CFG_Q13 = 3'd1,
		CFG_Q23 = 3'd2,
		CFG_Q32 = 3'd3,
		CFG_Q33 = 3'd4
	} cfg_idx_t;

	// One numerator headed into a divider lane, magnitude and sign split.
	typedef struct packed {
		logic [NumW-1:0] n_abs;
		logic            neg;
		logic            ovf;
	} lane_in_t;

endpackage

// ===== sv/disparity_to_3d_reprojection_unit.sv =====
// Channel   Direction  Bits  Contents
// s_axis    in         40    disparity, col, row
// m_axis    out        96+1  x_coord, y_coord, z_coord; tuser valid_res
// cfg       in         3+32  register index, write data
//
// One word enters per clock while the output is not stalled.
// Most of the pipeline is the divider lanes, which resolve one quotient bit per stage.
// All stages share one advance signal: the pipeline moves when the output
// register is empty or being taken, so a stall freezes every stage in place.
// Reset clears the valid bits and loads the configuration registers with their defaults.
module disparity_to_3d_reprojection_unit
	import d3r_pkg::*;
#(
	parameter int MAX_COLS = MaxColsDefault,
	parameter int MAX_ROWS = MaxRowsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [39:0]         s_axis_tdata,   // disparity[15:0], col[27:16], row[39:28]
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [95:0]         m_axis_tdata,   // x_coord[31:0], y_coord[63:32], z_coord[95:64]
	output logic                m_axis_tuser,   // valid_res
	input  logic                cfg_we,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [RegW-1:0]     cfg_wdata
);

	localparam int Depth = QuotW + 1;

	logic signed [RegW-1:0] q03_q, q13_q, q23_q, q32_q, q33_q;
	logic                   en;
	logic                   f_vld, f_ok;
	logic [DenW-1:0]        f_den;
	lane_in_t               f_x, f_y, f_z;
	logic [QuotW-1:0]       x_res, y_res, z_res;
	logic [Depth-1:0]       vld_q, ok_q;

	// Configuration registers; an index past the last register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q03_q <= '0;
			q13_q <= '0;
			q23_q <= '0;
			q32_q <= '0;
			q33_q <= 32'sd65536;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_Q03: q03_q <= cfg_wdata;
				CFG_Q13: q13_q <= cfg_wdata;
				CFG_Q23: q23_q <= cfg_wdata;
				CFG_Q32: q32_q <= cfg_wdata;
				CFG_Q33: q33_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	d3r_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(s_axis_tvalid),
		.disparity(s_axis_tdata[15:0]),
		.col(s_axis_tdata[27:16]),
		.row(s_axis_tdata[39:28]),
		.q03(q03_q), .q13(q13_q), .q23(q23_q), .q32(q32_q), .q33(q33_q),
		.out_vld(f_vld), .out_ok(f_ok), .den_abs(f_den),
		.lane_x(f_x), .lane_y(f_y), .lane_z(f_z)
	);

	// Three identical lanes share the denominator magnitude.
	d3r_div u_div_x (.clk(clk), .en(en), .din(f_x), .den(f_den), .quot(x_res));
	d3r_div u_div_y (.clk(clk), .en(en), .din(f_y), .den(f_den), .quot(y_res));
	d3r_div u_div_z (.clk(clk), .en(en), .din(f_z), .den(f_den), .quot(z_res));

	// Valid and result flag travel beside the divider stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			ok_q  <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Depth-2:0], f_vld};
			ok_q  <= {ok_q[Depth-2:0], f_ok};
		end
	end

	assign m_axis_tvalid = vld_q[Depth-1];
	assign m_axis_tuser  = ok_q[Depth-1];
	assign m_axis_tdata  = {z_res, y_res, x_res};

`ifndef NO_ASSERTIONS
	// A word flagged as having no valid point carries all-zero coordinates.
	a_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("invalid point with nonzero coordinates");

	// Input back-pressure only comes from a held result.
	a_ready_only_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output stall");

	// A bias write lands in its register.
	a_bias_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_addr == CFG_Q33 |=> q33_q == $past(cfg_wdata))
		else $error("bias register write lost");
`endif

endmodule

// ===== sv/d3r_front.sv =====
module d3r_front
	import d3r_pkg::*;
#(
	parameter int MAX_COLS = MaxColsDefault,
	parameter int MAX_ROWS = MaxRowsDefault
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  logic signed [DispW-1:0] disparity,
	input  logic [PixW-1:0]         col,
	input  logic [PixW-1:0]         row,
	input  logic signed [RegW-1:0]  q03,
	input  logic signed [RegW-1:0]  q13,
	input  logic signed [RegW-1:0]  q23,
	input  logic signed [RegW-1:0]  q32,
	input  logic signed [RegW-1:0]  q33,
	output logic                    out_vld,
	output logic                    out_ok,
	output logic [DenW-1:0]         den_abs,
	output lane_in_t                lane_x,
	output lane_in_t                lane_y,
	output lane_in_t                lane_z
);

	localparam int LimW = 17;

	// Stage 1: captured input word.
	logic                    vld_s1;
	logic signed [DispW-1:0] disp_s1;
	logic [PixW-1:0]         col_s1, row_s1;
	// Stage 2: product and numerators.
	logic                    vld_s2, frame_s2;
	logic signed [ProdW-1:0] prod_s2;
	logic signed [NumW-1:0]  nx_s2, ny_s2, nz_s2;
	// Stage 3: full denominator.
	logic                    vld_s3, frame_s3;
	logic signed [DenW-1:0]  w_s3;
	logic signed [NumW-1:0]  nx_s3, ny_s3, nz_s3;
	// Stage 4: magnitudes.
	logic                    vld_s4, ok_s4;
	logic [DenW-1:0]         wabs_s4;
	lane_in_t                lx_s4, ly_s4, lz_s4;

	logic signed [DenW-1:0]  w_c;
	logic [DenW-1:0]         wabs_c;
	logic                    ok_c;

	function automatic lane_in_t mk_lane(input logic signed [NumW-1:0] n,
		input logic signed [DenW-1:0] w, input logic [DenW-1:0] wa, input logic ok);
		lane_in_t l;
		logic [NumW-1:0] na;
		na = n[NumW-1] ? NumW'(-n) : NumW'(n);
		l.n_abs = ok ? na : '0;
		l.neg   = ok & (n[NumW-1] ^ w[DenW-1]);
		l.ovf   = ok & ({{(DenW-NumW){1'b0}}, na} >= wa);
		return l;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign w_c    = DenW'(w_s3);
	assign wabs_c = w_c[DenW-1] ? DenW'(-w_c) : DenW'(w_c);
	assign ok_c   = frame_s3 && (w_s3 != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			disp_s1  <= disparity;
			col_s1   <= col;
			row_s1   <= row;

			prod_s2  <= ProdW'(disp_s1) * ProdW'(q32);
			nx_s2    <= $signed({2'b00, col_s1, 16'h0000}) + NumW'(q03);
			ny_s2    <= $signed({2'b00, row_s1, 16'h0000}) + NumW'(q13);
			nz_s2    <= NumW'(q23);
			frame_s2 <= ({{(LimW-PixW){1'b0}}, col_s1} < LimW'(MAX_COLS))
			         && ({{(LimW-PixW){1'b0}}, row_s1} < LimW'(MAX_ROWS));

			w_s3     <= DenW'(prod_s2) + $signed({q33[RegW-1], q33, 16'h0000});
			nx_s3    <= nx_s2;
			ny_s3    <= ny_s2;
			nz_s3    <= nz_s2;
			frame_s3 <= frame_s2;

			ok_s4    <= ok_c;
			wabs_s4  <= ok_c ? wabs_c : DenW'(1);
			lx_s4    <= mk_lane(nx_s3, w_c, wabs_c, ok_c);
			ly_s4    <= mk_lane(ny_s3, w_c, wabs_c, ok_c);
			lz_s4    <= mk_lane(nz_s3, w_c, wabs_c, ok_c);
		end
	end

	assign out_vld = vld_s4;
	assign out_ok  = ok_s4;
	assign den_abs = wabs_s4;
	assign lane_x  = lx_s4;
	assign lane_y  = ly_s4;
	assign lane_z  = lz_s4;

endmodule

// ===== sv/d3r_div.sv =====
module d3r_div
	import d3r_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  lane_in_t         din,
	input  logic [DenW-1:0]  den,
	output logic [QuotW-1:0] quot
);

	// One quotient bit per stage, restoring division, then a stage that saturates and applies the sign.
	logic [RemW-1:0]  rem_s [0:QuotW];
	logic [QuotW-1:0] q_s   [0:QuotW];
	logic [DenW-1:0]  d_s   [0:QuotW];
	logic             neg_s [0:QuotW];
	logic             ovf_s [0:QuotW];
	logic [QuotW-1:0] res_q;

	always_comb begin
		rem_s[0] = {{(RemW-NumW){1'b0}}, din.n_abs};
		q_s[0]   = '0;
		d_s[0]   = den;
		neg_s[0] = din.neg;
		ovf_s[0] = din.ovf;
	end

	for (genvar k = 0; k < QuotW; k++) begin : g_step
		logic [RemW:0] sh;
		logic          ge;
		assign sh = {rem_s[k], 1'b0};
		assign ge = sh >= {1'b0, d_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? RemW'(sh - {1'b0, d_s[k]}) : sh[RemW-1:0];
				q_s[k+1]   <= {q_s[k][QuotW-2:0], ge};
				d_s[k+1]   <= d_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	logic [QuotW-1:0] lim_c, mag_c;
	assign lim_c = neg_s[QuotW] ? {1'b1, {(QuotW-1){1'b0}}} : {1'b0, {(QuotW-1){1'b1}}};
	assign mag_c = (ovf_s[QuotW] || q_s[QuotW] > lim_c) ? lim_c : q_s[QuotW];

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= neg_s[QuotW] ? QuotW'(-mag_c) : mag_c;
		end
	end

	assign quot = res_q;

endmodule
